// ===== hdl/hvt_pkg.sv =====
// Shared constants, types and helper functions of the homogeneous vertex transform.
package hvt_pkg;

   localparam int FRAC_BITS   = 16;
   localparam int DATA_W      = 32;
   localparam int NUM_PAIRS   = 8;
   localparam int PAIR_W      = 64;
   localparam int CSR_INDEX_W = 3;
   localparam int PROD_W      = 2 * DATA_W;
   localparam int SUM_W       = PROD_W + 2;
   localparam int ROUND_W     = SUM_W - FRAC_BITS;
   localparam int NUM_W       = DATA_W + 1 + FRAC_BITS;
   localparam int DIV_STEP    = 4;
   localparam int DIV_STAGES  = (NUM_W + DIV_STEP - 1) / DIV_STEP;
   localparam int NQ_W        = DIV_STAGES * DIV_STEP;
   localparam int REM_W       = DATA_W + 1;
   localparam int LANES       = 3;

   localparam logic REQ_POSITION  = 1'b0;
   localparam logic REQ_DIRECTION = 1'b1;

   localparam logic [DATA_W-1:0] ONE_FX = DATA_W'(64'd1 << FRAC_BITS);
   localparam logic [DATA_W-1:0] MAX_FX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic [DATA_W-1:0] MIN_FX = {1'b1, {(DATA_W-1){1'b0}}};

   typedef logic signed [DATA_W-1:0] fx_type;

   typedef struct packed {
      logic [REM_W-1:0]  rem;
      logic [NQ_W-1:0]   nq;
      logic [DATA_W-1:0] den;
   } div_lane_type;

   typedef struct packed {
      logic                         direction;
      logic                         sat_ov;
      logic                         zero_w;
      logic [LANES-1:0]             neg;
      logic [LANES-1:0][DATA_W-1:0] val;
   } div_side_type;

   // Identity matrix: an element sits on the diagonal when its row and column match.
   function automatic logic [PAIR_W-1:0] pair_reset(input logic [CSR_INDEX_W-1:0] k);
      logic [3:0] lo_idx;
      logic [3:0] hi_idx;
      logic [PAIR_W-1:0] res;
      lo_idx = {k[2:0], 1'b0};
      hi_idx = {k[2:0], 1'b1};
      res = '0;
      if (lo_idx[1:0] == lo_idx[3:2]) res[DATA_W-1:0] = ONE_FX;
      if (hi_idx[1:0] == hi_idx[3:2]) res[PAIR_W-1:DATA_W] = ONE_FX;
      return res;
   endfunction

   // A few restoring division steps: numerator bits shift out of nq while
   // quotient bits shift in at the bottom.
   function automatic div_lane_type div_steps(input div_lane_type l);
      div_lane_type r;
      logic [REM_W-1:0] trial;
      logic ge;
      r = l;
      for (int i = 0; i < DIV_STEP; i++) begin
         trial = {r.rem[REM_W-2:0], r.nq[NQ_W-1]};
         ge    = (trial >= REM_W'(r.den));
         r.rem = ge ? (trial - REM_W'(r.den)) : trial;
         r.nq  = {r.nq[NQ_W-2:0], ge};
      end
      return r;
   endfunction

endpackage

// ===== hdl/hvt_if.sv =====
// Valid/ready channel interfaces for vertex requests and transformed results.
interface hvt_req_if;
   logic                      valid;
   logic                      ready;
   logic                      req_type;
   logic signed [hvt_pkg::DATA_W-1:0] in_x;
   logic signed [hvt_pkg::DATA_W-1:0] in_y;
   logic signed [hvt_pkg::DATA_W-1:0] in_z;
   logic signed [hvt_pkg::DATA_W-1:0] in_w;
   modport source(output valid, req_type, in_x, in_y, in_z, in_w, input ready);
   modport sink(input valid, req_type, in_x, in_y, in_z, in_w, output ready);
endinterface

interface hvt_rsp_if;
   logic                      valid;
   logic                      ready;
   logic signed [hvt_pkg::DATA_W-1:0] out_x;
   logic signed [hvt_pkg::DATA_W-1:0] out_y;
   logic signed [hvt_pkg::DATA_W-1:0] out_z;
   logic signed [hvt_pkg::DATA_W-1:0] out_w;
   logic                      overflow_flag;
   logic                      zero_w_flag;
   modport source(output valid, out_x, out_y, out_z, out_w, overflow_flag, zero_w_flag,
                  input ready);
   modport sink(input valid, out_x, out_y, out_z, out_w, overflow_flag, zero_w_flag,
                output ready);
endinterface

// ===== hdl/homogeneous_vertex_transform.sv =====
// Top level: 4x4 fixed-point vertex transform with perspective divide.
//
//   channel   kind        handshake          payload
//   req_chan  vertex in   valid/ready        req_type, in_x, in_y, in_z, in_w
//   rsp_chan  result out  valid/ready        out_x..out_w, overflow_flag, zero_w_flag
//   csr_*     matrix      write enable only  index 0..7, 64-bit data
//
// One vertex can enter every cycle while no stage is stalled; a result is offered once its beat
// has passed the input register, four arithmetic stages, thirteen divider stages
// and the output register.
// The divider resolves four quotient bits per stage.
// Reset clears all stage valid bits and loads the identity matrix.
// Each stage holds its beat while the next is full and stalled; bubbles close up.
module homogeneous_vertex_transform (
   input  logic                                clock,
   input  logic                                reset,
   hvt_req_if.sink                             req_chan,
   hvt_rsp_if.source                           rsp_chan,
   input  logic                                csr_write_en,
   input  logic [hvt_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [hvt_pkg::PAIR_W-1:0]          csr_wdata
);

   localparam int DW = hvt_pkg::DATA_W;
   localparam logic signed [hvt_pkg::SUM_W-1:0] HALF_SUM =
      hvt_pkg::SUM_W'(1) << (hvt_pkg::FRAC_BITS - 1);
   localparam logic signed [hvt_pkg::ROUND_W-1:0] SAT_HI =
      hvt_pkg::ROUND_W'($signed(hvt_pkg::MAX_FX));
   localparam logic signed [hvt_pkg::ROUND_W-1:0] SAT_LO =
      hvt_pkg::ROUND_W'($signed(hvt_pkg::MIN_FX));

   // Matrix registers.
   logic [hvt_pkg::PAIR_W-1:0] pair_ff [hvt_pkg::NUM_PAIRS];
   logic signed [DW-1:0] mat [4][4];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < hvt_pkg::NUM_PAIRS; k++) begin
            pair_ff[k] <= hvt_pkg::pair_reset(hvt_pkg::CSR_INDEX_W'(k));
         end
      end else if (csr_write_en) begin
         pair_ff[csr_index] <= csr_wdata;
      end
   end

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            mat[r][c] = c[0] ? pair_ff[r*2 + c/2][hvt_pkg::PAIR_W-1:DW]
                             : pair_ff[r*2 + c/2][DW-1:0];
         end
      end
   end

   // Stage valid bits and the ready chain.
   logic v0_ff, v1_ff, v2_ff, v3_ff, v4_ff, rsp_valid_ff;
   logic rdy0, rdy1, rdy2, rdy3, rdy4, out_rdy;
   logic div_in_ready, div_out_valid;

   assign out_rdy = !rsp_valid_ff || rsp_chan.ready;
   assign rdy4    = !v4_ff || div_in_ready;
   assign rdy3    = !v3_ff || rdy4;
   assign rdy2    = !v2_ff || rdy3;
   assign rdy1    = !v1_ff || rdy2;
   assign rdy0    = !v0_ff || rdy1;
   assign req_chan.ready = rdy0;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff        <= 1'b0;
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rdy0)    v0_ff        <= req_chan.valid;
         if (rdy1)    v1_ff        <= v0_ff;
         if (rdy2)    v2_ff        <= v1_ff;
         if (rdy3)    v3_ff        <= v2_ff;
         if (rdy4)    v4_ff        <= v3_ff;
         if (out_rdy) rsp_valid_ff <= div_out_valid;
      end
   end

   // Stage 0: capture the vertex.
   logic                 dir0_ff;
   logic signed [DW-1:0] vec0_ff [4];

   always_ff @(posedge clock) begin
      if (rdy0 && req_chan.valid) begin
         dir0_ff    <= req_chan.req_type;
         vec0_ff[0] <= req_chan.in_x;
         vec0_ff[1] <= req_chan.in_y;
         vec0_ff[2] <= req_chan.in_z;
         vec0_ff[3] <= req_chan.in_w;
      end
   end

   // Stage 1: sixteen products.
   logic                             dir1_ff;
   logic signed [hvt_pkg::PROD_W-1:0] prod1_in [4][4];
   logic signed [hvt_pkg::PROD_W-1:0] prod1_ff [4][4];

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         for (int c = 0; c < 4; c++) begin
            prod1_in[r][c] = mat[r][c] * vec0_ff[c];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy1 && v0_ff) begin
         dir1_ff  <= dir0_ff;
         prod1_ff <= prod1_in;
      end
   end

   // Stage 2: exact row sums, rounded half up to the fixed-point grid.
   logic                              dir2_ff;
   logic signed [hvt_pkg::SUM_W-1:0]   sum2 [4];
   logic signed [hvt_pkg::ROUND_W-1:0] rnd2_in [4];
   logic signed [hvt_pkg::ROUND_W-1:0] rnd2_ff [4];

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         sum2[r] = prod1_ff[r][0] + prod1_ff[r][1] + prod1_ff[r][2] + prod1_ff[r][3]
                   + HALF_SUM;
         rnd2_in[r] = hvt_pkg::ROUND_W'(sum2[r] >>> hvt_pkg::FRAC_BITS);
      end
   end

   always_ff @(posedge clock) begin
      if (rdy2 && v1_ff) begin
         dir2_ff <= dir1_ff;
         rnd2_ff <= rnd2_in;
      end
   end

   // Stage 3: saturate each row to 32 bits.
   logic                 dir3_ff;
   logic signed [DW-1:0] sat3_in [4];
   logic signed [DW-1:0] sat3_ff [4];
   logic [3:0]           ovr3_in, ovr3_ff;

   always_comb begin
      for (int r = 0; r < 4; r++) begin
         ovr3_in[r] = 1'b1;
         if (rnd2_ff[r] > SAT_HI) begin
            sat3_in[r] = hvt_pkg::MAX_FX;
         end else if (rnd2_ff[r] < SAT_LO) begin
            sat3_in[r] = hvt_pkg::MIN_FX;
         end else begin
            sat3_in[r] = rnd2_ff[r][DW-1:0];
            ovr3_in[r] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (rdy3 && v2_ff) begin
         dir3_ff <= dir2_ff;
         sat3_ff <= sat3_in;
         ovr3_ff <= ovr3_in;
      end
   end

   // Stage 4: magnitudes and rounded numerators for the divider.
   hvt_pkg::div_lane_type [hvt_pkg::LANES-1:0] lane4_in, lane4_ff;
   hvt_pkg::div_side_type                      side4_in, side4_ff;
   logic [DW-1:0] den_mag;
   logic [DW-1:0] num_mag [hvt_pkg::LANES];

   always_comb begin
      den_mag = sat3_ff[3][DW-1] ? (~sat3_ff[3] + 1'b1) : sat3_ff[3];
      side4_in.direction = dir3_ff;
      side4_in.sat_ov    = (dir3_ff == hvt_pkg::REQ_DIRECTION) ? (|ovr3_ff[2:0]) : (|ovr3_ff);
      side4_in.zero_w    = (dir3_ff == hvt_pkg::REQ_POSITION) && (sat3_ff[3] == '0);
      for (int i = 0; i < hvt_pkg::LANES; i++) begin
         num_mag[i] = sat3_ff[i][DW-1] ? (~sat3_ff[i] + 1'b1) : sat3_ff[i];
         lane4_in[i].rem = '0;
         lane4_in[i].den = den_mag;
         lane4_in[i].nq  = (hvt_pkg::NQ_W'(num_mag[i]) << hvt_pkg::FRAC_BITS)
                           + hvt_pkg::NQ_W'(den_mag >> 1);
         side4_in.neg[i] = sat3_ff[i][DW-1] ^ sat3_ff[3][DW-1];
         side4_in.val[i] = sat3_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (rdy4 && v3_ff) begin
         lane4_ff <= lane4_in;
         side4_ff <= side4_in;
      end
   end

   hvt_pkg::div_lane_type [hvt_pkg::LANES-1:0] div_lane;
   hvt_pkg::div_side_type                      div_side;

   hvt_div u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (v4_ff),
      .in_ready  (div_in_ready),
      .in_lane   (lane4_ff),
      .in_side   (side4_ff),
      .out_valid (div_out_valid),
      .out_ready (out_rdy),
      .out_lane  (div_lane),
      .out_side  (div_side)
   );

   // Output stage: sign, saturate the quotients and pick the mode's result.
   logic [DW-1:0] res_in [4];
   logic [DW-1:0] res_ff [4];
   logic          ov_in, ov_ff, zw_in, zw_ff;
   logic [DW-1:0] quo [hvt_pkg::LANES];
   logic [hvt_pkg::LANES-1:0] qov;
   logic [hvt_pkg::NQ_W-1:0] q;

   always_comb begin
      for (int i = 0; i < hvt_pkg::LANES; i++) begin
         q = div_lane[i].nq;
         if (div_side.neg[i]) begin
            qov[i] = q > hvt_pkg::NQ_W'(hvt_pkg::MIN_FX);
            quo[i] = qov[i] ? hvt_pkg::MIN_FX : (~q[DW-1:0] + 1'b1);
         end else begin
            qov[i] = q > hvt_pkg::NQ_W'(hvt_pkg::MAX_FX);
            quo[i] = qov[i] ? hvt_pkg::MAX_FX : q[DW-1:0];
         end
      end
      zw_in = div_side.zero_w;
      if (div_side.direction == hvt_pkg::REQ_DIRECTION) begin
         for (int i = 0; i < hvt_pkg::LANES; i++) res_in[i] = div_side.val[i];
         res_in[3] = '0;
         ov_in     = div_side.sat_ov;
      end else if (div_side.zero_w) begin
         for (int i = 0; i < 4; i++) res_in[i] = '0;
         ov_in = 1'b0;
      end else begin
         for (int i = 0; i < hvt_pkg::LANES; i++) res_in[i] = quo[i];
         res_in[3] = hvt_pkg::ONE_FX;
         ov_in     = div_side.sat_ov || (|qov);
      end
   end

   always_ff @(posedge clock) begin
      if (out_rdy && div_out_valid) begin
         res_ff <= res_in;
         ov_ff  <= ov_in;
         zw_ff  <= zw_in;
      end
   end

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.out_x         = res_ff[0];
   assign rsp_chan.out_y         = res_ff[1];
   assign rsp_chan.out_z         = res_ff[2];
   assign rsp_chan.out_w         = res_ff[3];
   assign rsp_chan.overflow_flag = ov_ff;
   assign rsp_chan.zero_w_flag   = zw_ff;

   // A zero divisor yields an all-zero result with no overflow.
   a_zero_w_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && zw_ff |-> !ov_ff && res_ff[0] == '0 && res_ff[3] == '0)
      else $error("zero w result not cleared");

   // The w component is always 1.0 or 0.
   a_w_value: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> res_ff[3] == hvt_pkg::ONE_FX || res_ff[3] == '0)
      else $error("unexpected w value");

   // Nothing leaves the pipeline in the cycle after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid_ff)
      else $error("result valid right after reset");

endmodule

// ===== hdl/hvt_div.sv =====
// Pipelined three-lane restoring divider, a few quotient bits per stage.
module hvt_div (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     in_valid,
   output logic                                     in_ready,
   input  hvt_pkg::div_lane_type [hvt_pkg::LANES-1:0] in_lane,
   input  hvt_pkg::div_side_type                    in_side,
   output logic                                     out_valid,
   input  logic                                     out_ready,
   output hvt_pkg::div_lane_type [hvt_pkg::LANES-1:0] out_lane,
   output hvt_pkg::div_side_type                    out_side
);

   localparam int LAST = hvt_pkg::DIV_STAGES - 1;

   logic [hvt_pkg::DIV_STAGES-1:0] valid_ff;
   logic [hvt_pkg::DIV_STAGES-1:0] stage_ready;
   hvt_pkg::div_lane_type [hvt_pkg::LANES-1:0] lane_ff [hvt_pkg::DIV_STAGES];
   hvt_pkg::div_side_type                      side_ff [hvt_pkg::DIV_STAGES];
   hvt_pkg::div_lane_type [hvt_pkg::LANES-1:0] lane_in [hvt_pkg::DIV_STAGES];
   hvt_pkg::div_side_type                      side_in [hvt_pkg::DIV_STAGES];
   logic [hvt_pkg::DIV_STAGES-1:0] valid_in;

   // A stage may load when it is empty or its content moves on this cycle.
   always_comb begin
      stage_ready[LAST] = !valid_ff[LAST] || out_ready;
      for (int s = LAST - 1; s >= 0; s--) begin
         stage_ready[s] = !valid_ff[s] || stage_ready[s+1];
      end
   end

   always_comb begin
      valid_in[0] = in_valid;
      side_in[0]  = in_side;
      for (int l = 0; l < hvt_pkg::LANES; l++) begin
         lane_in[0][l] = hvt_pkg::div_steps(in_lane[l]);
      end
      for (int s = 1; s < hvt_pkg::DIV_STAGES; s++) begin
         valid_in[s] = valid_ff[s-1];
         side_in[s]  = side_ff[s-1];
         for (int l = 0; l < hvt_pkg::LANES; l++) begin
            lane_in[s][l] = hvt_pkg::div_steps(lane_ff[s-1][l]);
         end
      end
   end

   always_ff @(posedge clock) begin
      for (int s = 0; s < hvt_pkg::DIV_STAGES; s++) begin
         if (reset) begin
            valid_ff[s] <= 1'b0;
         end else if (stage_ready[s]) begin
            valid_ff[s] <= valid_in[s];
         end
         if (stage_ready[s] && valid_in[s]) begin
            lane_ff[s] <= lane_in[s];
            side_ff[s] <= side_in[s];
         end
      end
   end

   assign in_ready  = stage_ready[0];
   assign out_valid = valid_ff[LAST];
   assign out_lane  = lane_ff[LAST];
   assign out_side  = side_ff[LAST];

endmodule

// ===== sim/hvt_checker.sv =====
// Checker for the vertex transform: watches both channels, predicts and compares results.
module hvt_checker (
   input  logic           clock,
   input  logic           reset,
   hvt_req_if             req_chan,
   hvt_rsp_if             rsp_chan,
   input  logic           csr_write_en,
   input  logic [2:0]     csr_index,
   input  logic [63:0]    csr_wdata,
   output int             fail_count,
   output int             pending_count
);
   import hvt_pkg::*;

   typedef struct {
      logic [31:0] x, y, z, w;
      logic        ovf, zw;
   } vertex_result_t;

   logic [63:0]    matrix_regs [NUM_PAIRS];
   vertex_result_t expected_vertices [$];

   assign pending_count = expected_vertices.size();

   function automatic longint matrix_elem(int idx);
      logic [63:0] pair;
      pair = matrix_regs[idx >> 1];
      return (idx & 1) ? longint'($signed(pair[63:32])) : longint'($signed(pair[31:0]));
   endfunction

   function automatic longint floor_frac(longint v);
      return v >>> FRAC_BITS;
   endfunction

   // Exact sum of the four products, then round half up.
   function automatic longint row_sum(int row, longint v[4]);
      longint hi, lo, p, h;
      hi = 0;
      lo = 0;
      for (int c = 0; c < 4; c++) begin
         p = matrix_elem(row * 4 + c) * v[c];
         h = floor_frac(p);
         hi += h;
         lo += p - (h <<< FRAC_BITS);
      end
      lo += longint'(1) <<< (FRAC_BITS - 1);
      return hi + floor_frac(lo);
   endfunction

   function automatic longint clamp32(longint v, ref logic ovf);
      if (v > 64'sd2147483647) begin
         ovf = 1'b1;
         return 64'sd2147483647;
      end
      if (v < -64'sd2147483648) begin
         ovf = 1'b1;
         return -64'sd2147483648;
      end
      return v;
   endfunction

   function automatic longint divide_fx(longint num, longint den, ref logic ovf);
      logic [63:0] n, d, q;
      logic        neg;
      n = (num < 0 ? -num : num) << FRAC_BITS;
      d = den < 0 ? -den : den;
      q = (n + d / 2) / d;
      neg = (num < 0) != (den < 0);
      if (neg) begin
         if (q > 64'h8000_0000) begin
            ovf = 1'b1;
            return -64'sd2147483648;
         end
         return -longint'(q);
      end
      if (q > 64'h7fff_ffff) begin
         ovf = 1'b1;
         return 64'sd2147483647;
      end
      return longint'(q);
   endfunction

   function automatic vertex_result_t transform_vertex(logic kind, logic [31:0] ix,
         logic [31:0] iy, logic [31:0] iz, logic [31:0] iw);
      longint         v[4];
      longint         t[4];
      vertex_result_t r;
      logic           ovf;
      v[0] = $signed(ix);
      v[1] = $signed(iy);
      v[2] = $signed(iz);
      v[3] = $signed(iw);
      ovf = 1'b0;
      r.zw = 1'b0;
      if (kind == REQ_DIRECTION) begin
         for (int i = 0; i < 3; i++) t[i] = clamp32(row_sum(i, v), ovf);
         r.x = t[0][31:0];
         r.y = t[1][31:0];
         r.z = t[2][31:0];
         r.w = '0;
      end else begin
         for (int i = 0; i < 4; i++) t[i] = clamp32(row_sum(i, v), ovf);
         if (t[3] == 0) begin
            r.zw = 1'b1;
            ovf = 1'b0;
            r.x = '0;
            r.y = '0;
            r.z = '0;
            r.w = '0;
         end else begin
            r.x = divide_fx(t[0], t[3], ovf);
            r.y = divide_fx(t[1], t[3], ovf);
            r.z = divide_fx(t[2], t[3], ovf);
            r.w = ONE_FX;
         end
      end
      r.ovf = ovf;
      return r;
   endfunction

   always @(posedge clock) begin
      vertex_result_t e;
      if (reset) begin
         for (int k = 0; k < NUM_PAIRS; k++) matrix_regs[k] <= pair_reset(k[2:0]);
         fail_count <= 0;
      end else begin
         if (csr_write_en) matrix_regs[csr_index] <= csr_wdata;
         if (req_chan.valid && req_chan.ready)
            expected_vertices.push_back(transform_vertex(req_chan.req_type, req_chan.in_x,
               req_chan.in_y, req_chan.in_z, req_chan.in_w));
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (expected_vertices.size() == 0) begin
               $error("result beat with no vertex outstanding");
               fail_count <= fail_count + 1;
            end else begin
               e = expected_vertices.pop_front();
               if (rsp_chan.out_x !== e.x || rsp_chan.out_y !== e.y ||
                   rsp_chan.out_z !== e.z || rsp_chan.out_w !== e.w ||
                   rsp_chan.overflow_flag !== e.ovf || rsp_chan.zero_w_flag !== e.zw)
                  fail_count <= fail_count + 1;
               if (rsp_chan.out_x !== e.x)
                  $error("out_x expected %h actual %h", e.x, rsp_chan.out_x);
               if (rsp_chan.out_y !== e.y)
                  $error("out_y expected %h actual %h", e.y, rsp_chan.out_y);
               if (rsp_chan.out_z !== e.z)
                  $error("out_z expected %h actual %h", e.z, rsp_chan.out_z);
               if (rsp_chan.out_w !== e.w)
                  $error("out_w expected %h actual %h", e.w, rsp_chan.out_w);
               if (rsp_chan.overflow_flag !== e.ovf)
                  $error("overflow_flag expected %b actual %b", e.ovf,
                     rsp_chan.overflow_flag);
               if (rsp_chan.zero_w_flag !== e.zw)
                  $error("zero_w_flag expected %b actual %b", e.zw, rsp_chan.zero_w_flag);
            end
         end
      end
   end
endmodule

// ===== sim/homogeneous_vertex_transform_test.sv =====
// Testbench top: clock, reset, vertex stimulus, matrix settings and the verdict.
module homogeneous_vertex_transform_test;
   import hvt_pkg::*;

   localparam int LATENCY     = 19;
   localparam int CYCLE_LIMIT = 400000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        csr_write_en = 1'b0;
   logic [2:0]  csr_index = '0;
   logic [63:0] csr_wdata = '0;
   int          fail_count;
   int          pending_count;
   int          cycle_count = 0;
   bit          busy_idle = 1'b1;
   bit          hold_off = 1'b0;

   hvt_req_if req_chan ();
   hvt_rsp_if rsp_chan ();

   homogeneous_vertex_transform DUT (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata)
   );

   hvt_checker checker_inst (
      .clock(clock), .reset(reset), .req_chan(req_chan), .rsp_chan(rsp_chan),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_wdata(csr_wdata),
      .fail_count(fail_count), .pending_count(pending_count)
   );

   always #2 clock = ~clock;

   initial begin
      req_chan.valid = 1'b0;
      req_chan.req_type = 1'b0;
      req_chan.in_x = '0;
      req_chan.in_y = '0;
      req_chan.in_z = '0;
      req_chan.in_w = '0;
      rsp_chan.ready = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // Result side: random stalls, one long hold-off while input keeps flowing.
   always @(negedge clock) begin
      if (hold_off) rsp_chan.ready <= 1'b0;
      else if (busy_idle) rsp_chan.ready <= ($urandom_range(99) >= 30);
      else rsp_chan.ready <= 1'b1;
   end

   function automatic logic [31:0] random_component();
      case ($urandom_range(5))
         0: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
         1: return $urandom;
         2: return 32'($signed($urandom_range(0, 32'h000a_0000)) - 32'sh0005_0000);
         3: return $urandom_range(1) ? 32'h0001_0000 : 32'h0000_0000;
         default: return 32'($signed($urandom_range(0, 32'h0200_0000)) - 32'sh0100_0000);
      endcase
   endfunction

   // Valid stays high after the beat is taken; the next idle cycle or drain drops it.
   task automatic send_vertex(logic kind, logic [31:0] x, logic [31:0] y,
         logic [31:0] z, logic [31:0] w);
      while (busy_idle && $urandom_range(99) < 30) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid <= 1'b1;
      req_chan.req_type <= kind;
      req_chan.in_x <= x;
      req_chan.in_y <= y;
      req_chan.in_z <= z;
      req_chan.in_w <= w;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   task automatic drain();
      req_chan.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (LATENCY + 4) @(negedge clock);
   endtask

   // The write enable stays high across back-to-back writes; callers drop it.
   task automatic write_pair(logic [2:0] idx, logic [63:0] value);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
   endtask

   task automatic random_vertices(int count);
      logic kind;
      for (int n = 0; n < count; n++) begin
         kind = $urandom_range(1);
         // Position beats with a zero w are common under the identity matrix.
         send_vertex(kind, random_component(), random_component(), random_component(),
            ($urandom_range(15) == 0) ? 32'h0 : random_component());
      end
   endtask

   function automatic logic [31:0] random_elem();
      case ($urandom_range(4))
         0: return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
         1: return $urandom;
         2: return 32'h0;
         default: return 32'($signed($urandom_range(0, 32'h0004_0000)) - 32'sh0002_0000);
      endcase
   endfunction

   initial begin
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed beats under the identity matrix.
      send_vertex(REQ_POSITION, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0001_0000);
      send_vertex(REQ_POSITION, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'h0);
      send_vertex(REQ_POSITION, 32'h7fff_ffff, 32'h8000_0000, 32'h0000_0001, 32'h0000_0001);
      send_vertex(REQ_POSITION, 32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'hffff_ffff);
      send_vertex(REQ_POSITION, 32'h0000_0001, 32'h0000_0003, 32'hffff_ffff, 32'h0002_0000);
      send_vertex(REQ_POSITION, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000);
      send_vertex(REQ_DIRECTION, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff, 32'h0);
      send_vertex(REQ_DIRECTION, 32'h0001_8000, 32'h0, 32'h0, 32'h7fff_ffff);
      drain();

      // Extreme matrix: every element at its limits, so row sums can saturate.
      for (int k = 0; k < NUM_PAIRS; k++)
         write_pair(k[2:0], (k % 2) ? 64'h8000_0000_7fff_ffff : 64'h7fff_ffff_8000_0000);
      csr_write_en <= 1'b0;
      send_vertex(REQ_DIRECTION, 32'h7fff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h1);
      send_vertex(REQ_POSITION, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000);
      send_vertex(REQ_POSITION, 32'h0000_8000, 32'h0, 32'h0, 32'h0);
      send_vertex(REQ_POSITION, 32'h0001_0000, 32'h0001_0000, 32'h0, 32'h0);
      random_vertices(10);
      drain();

      // Back to identity for a random phase with the long output hold-off.
      for (int k = 0; k < NUM_PAIRS; k++) write_pair(k[2:0], pair_reset(k[2:0]));
      csr_write_en <= 1'b0;
      fork
         random_vertices(400);
         begin
            repeat (50) @(negedge clock);
            hold_off = 1'b1;
            repeat (150) @(negedge clock);
            hold_off = 1'b0;
         end
      join
      drain();

      // Random matrices; one phase runs with no idling at all.
      for (int phase = 0; phase < 6; phase++) begin
         for (int k = 0; k < NUM_PAIRS; k++) write_pair(k[2:0], {random_elem(), random_elem()});
         csr_write_en <= 1'b0;
         busy_idle = (phase != 2);
         random_vertices(240);
         drain();
      end
      busy_idle = 1'b1;

      if (fail_count == 0) $display("RESULT: OK");
      else $display("RESULT: ERROR");
      $finish;
   end
endmodule

// ===== homogeneous_vertex_transform.f =====
hdl/hvt_pkg.sv
hdl/hvt_if.sv
hdl/hvt_div.sv
hdl/homogeneous_vertex_transform.sv
sim/hvt_checker.sv
sim/homogeneous_vertex_transform_test.sv
